/* hw/rtl/onma_pkg.sv */
package onma_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ID_BITS    = 16;
    localparam int COLOR_BITS = 32;
    localparam int ENTRY_BITS = ID_BITS + COLOR_BITS;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int DIM_BITS   = 11;
    localparam int ROW_BITS   = DIM_BITS + 1;
    localparam int CHANNELS   = 4;
    localparam int CH_BITS    = 8;
    localparam int SUM_BITS   = CH_BITS + 3;
    localparam int NEIGHBOURS = 8;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    localparam logic [DIM_BITS-1:0] MAX_WIDTH_DIM = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] WIDTH_RESET   = 11'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET  = 11'd480;

    localparam logic [1:0] REG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_BACKGROUND = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [COLOR_BITS-1:0] color;
    } t_entry;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [COLOR_BITS-1:0] background;
        logic                  restart;
    } t_cfg;

    typedef struct packed {
        logic   valid;
        logic   shift;
        logic   emit_eol;
        logic   emit_mid;
        logic   last;
        logic   left_ok;
        logic   top_ok;
        logic   mid_ok;
        logic   bot_ok;
        logic   bank;
        t_entry bot;
    } t_s1;

endpackage

/* hw/rtl/onma_ram.sv */
module onma_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/onma_regs.sv */
module onma_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [onma_pkg::ADDR_BITS-1:0] paddr,
    input  logic [onma_pkg::DATA_BITS-1:0] pwdata,
    output logic [onma_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output onma_pkg::t_cfg                 o_cfg
);
    import onma_pkg::*;

    logic [DIM_BITS-1:0]   r_width;
    logic [DIM_BITS-1:0]   r_height;
    logic [COLOR_BITS-1:0] r_background;
    logic [1:0]            reg_idx;
    logic                  wr;

    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_background <= '0;
        end else if (wr) begin
            case (reg_idx)
                REG_WIDTH:      r_width      <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT:     r_height     <= pwdata[DIM_BITS-1:0];
                REG_BACKGROUND: r_background <= pwdata[COLOR_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:      prdata = DATA_BITS'(r_width);
            REG_HEIGHT:     prdata = DATA_BITS'(r_height);
            REG_BACKGROUND: prdata = DATA_BITS'(r_background);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.width      = r_width;
    assign o_cfg.height     = r_height;
    assign o_cfg.background = r_background;
    assign o_cfg.restart    = wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

endmodule

/* hw/rtl/onma_ctrl.sv */
module onma_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  onma_pkg::t_cfg                  i_cfg,
    input  logic                            i_valid,
    input  logic                            i_kind,
    input  logic [onma_pkg::COLOR_BITS-1:0] i_color,
    input  logic [15:0]                     i_id,
    input  logic                            i_out_free,
    output logic                            o_ready,
    output onma_pkg::t_s1                   o_s1,
    output logic                            o_ram_re,
    output logic [onma_pkg::COL_BITS-1:0]   o_ram_addr,
    output logic [1:0]                      o_ram_we,
    output onma_pkg::t_entry                o_ram_wdata
);
    import onma_pkg::*;

    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    t_s1                 r_s1, n_s1;

    logic [DIM_BITS-1:0] w_eff;
    logic [ROW_BITS-1:0] h_ext;
    logic [COL_BITS-1:0] c0;
    logic [ROW_BITS-1:0] r0;
    logic [DIM_BITS-1:0] col_inc;
    logic                accept, drop, last, eol, bot_ok;
    t_entry              in_entry;

    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = DIM_BITS'(1);
        end else if (i_cfg.width > MAX_WIDTH_DIM) begin
            w_eff = MAX_WIDTH_DIM;
        end else begin
            w_eff = i_cfg.width;
        end
        h_ext = (i_cfg.height == '0) ? ROW_BITS'(1) : ROW_BITS'(i_cfg.height);
    end

    always_comb begin
        if (DIM_BITS'(r_col) >= w_eff || r_row > h_ext + ROW_BITS'(1)) begin
            c0 = '0;
            r0 = '0;
        end else begin
            c0 = r_col;
            r0 = r_row;
        end
        o_ready = !r_s1.valid || i_out_free;
        accept  = i_valid && o_ready;
        bot_ok  = r0 < h_ext;
        drop    = bot_ok && (i_kind == KIND_FLUSH);
        last    = r0 == h_ext + ROW_BITS'(1);
        eol     = (c0 == '0) && (r0 >= ROW_BITS'(2));
        col_inc = DIM_BITS'(c0) + DIM_BITS'(1);

        if (drop) begin
            n_col = c0;
            n_row = r0;
        end else if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = r0 + ROW_BITS'(1);
        end else begin
            n_col = col_inc[COL_BITS-1:0];
            n_row = r0;
        end

        in_entry.id    = i_id[ID_BITS-1:0];
        in_entry.color = i_color;

        n_s1.valid    = accept;
        n_s1.shift    = !drop && !last;
        n_s1.emit_eol = !drop && eol;
        n_s1.emit_mid = !drop && !last && (c0 != '0) && (r0 != '0);
        n_s1.last     = last;
        n_s1.left_ok  = eol ? (w_eff >= DIM_BITS'(2)) : (c0 >= COL_BITS'(2));
        n_s1.top_ok   = r0 >= ROW_BITS'(2);
        n_s1.mid_ok   = (r0 != '0) && (r0 <= h_ext);
        n_s1.bot_ok   = bot_ok;
        n_s1.bank     = r0[0];
        n_s1.bot      = in_entry;
    end

    assign o_ram_re    = accept;
    assign o_ram_addr  = c0;
    assign o_ram_wdata = in_entry;
    assign o_ram_we[0] = accept && !drop && bot_ok && !r0[0];
    assign o_ram_we[1] = accept && !drop && bot_ok && r0[0];
    assign o_s1        = r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else begin
            if (i_cfg.restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_s1 <= n_s1;
            end
        end
    end

endmodule

/* hw/rtl/onma_window.sv */
module onma_window (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  onma_pkg::t_s1                   i_s1,
    input  onma_pkg::t_entry                i_line0,
    input  onma_pkg::t_entry                i_line1,
    input  logic [onma_pkg::COLOR_BITS-1:0] i_background,
    input  logic                            i_out_ready,
    output logic                            o_out_free,
    output logic                            o_out_valid,
    output logic [onma_pkg::COLOR_BITS-1:0] o_color,
    output logic                            o_last
);
    import onma_pkg::*;

    t_entry                r_win [3][3];
    logic                  r_out_valid;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    t_entry                new_col [3];
    t_entry                cand [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] cand_en;
    logic [NEIGHBOURS-1:0] hit;
    logic [SUM_BITS-1:0]   sums [CHANNELS];
    logic [ID_BITS-1:0]    center_id;
    logic [COLOR_BITS-1:0] avg;
    logic                  emit;

    // top row is the line two rows up, middle the line above
    always_comb begin
        new_col[0] = i_s1.top_ok ? (i_s1.bank ? i_line1 : i_line0) : '0;
        new_col[1] = i_s1.mid_ok ? (i_s1.bank ? i_line0 : i_line1) : '0;
        new_col[2] = i_s1.bot_ok ? i_s1.bot : '0;
    end

    always_comb begin
        center_id = r_win[1][2].id;
        cand[0] = r_win[0][1];
        cand[1] = r_win[1][1];
        cand[2] = r_win[2][1];
        cand[3] = r_win[0][2];
        cand[4] = r_win[2][2];
        cand[5] = new_col[0];
        cand[6] = new_col[1];
        cand[7] = new_col[2];
        cand_en = {{3{i_s1.emit_mid}}, 2'b11, {3{i_s1.left_ok}}};
        for (int k = 0; k < NEIGHBOURS; k++) begin
            hit[k] = cand_en[k] && (cand[k].id == center_id);
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sums[ch] = '0;
            for (int k = 0; k < NEIGHBOURS; k++) begin
                if (hit[k]) begin
                    sums[ch] = sums[ch] + SUM_BITS'(cand[k].color[CH_BITS*ch +: CH_BITS]);
                end
            end
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            avg[CH_BITS*ch +: CH_BITS] = sums[ch][SUM_BITS-1:3];
        end
        if (center_id == '0) begin
            avg = i_background;
        end
    end

    assign emit        = i_s1.valid && (i_s1.emit_eol || i_s1.emit_mid);
    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_color     = r_out_color;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int row = 0; row < 3; row++) begin
                for (int col = 0; col < 3; col++) begin
                    r_win[row][col] <= '0;
                end
            end
        end else if (o_out_free) begin
            r_out_valid <= emit;
            if (emit) begin
                r_out_color <= avg;
                r_out_last  <= i_s1.emit_eol && i_s1.last;
            end
            if (i_s1.valid && i_s1.shift) begin
                for (int row = 0; row < 3; row++) begin
                    r_win[row][0] <= r_win[row][1];
                    r_win[row][1] <= r_win[row][2];
                    r_win[row][2] <= new_col[row];
                end
            end
        end
    end

endmodule

/* hw/rtl/object_masked_neighbour_average_unit.sv */
// Masked 3x3 neighbour average over a raster stream, one pixel per clock while the result side is not stalled.
// Each pixel beat carries a colour and an object id; every pixel gets one result,
// the background colour when its id is 0, else the per-channel sum of the
// same-id neighbours inside the frame divided by 8. Results trail the input by
// one line plus one pixel, so width + 1 flush beats (tuser high) after the
// frame drain the last line; flush beats that arrive before the last pixel are
// dropped, pixel beats after it count as flush. Sustained rate is one beat per
// cycle while the result register is free: the line-store read and the stage
// register load when a beat is accepted, and the window update then loads the
// result register from the stage register once the result register is free.
// A stalled result register holds the input. Writing width or height restarts
// the frame position.
module object_masked_neighbour_average_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pixel_color[31:0], object_id[47:32]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // filtered_color[31:0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import onma_pkg::*;

    t_cfg                cfg;
    t_s1                 s1;
    logic                out_free;
    logic                ram_re;
    logic [COL_BITS-1:0] ram_addr;
    logic [1:0]          ram_we;
    t_entry              ram_wdata;
    t_entry              line0;
    t_entry              line1;

    onma_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    onma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (s_axis_tvalid),
        .i_kind      (s_axis_tuser),
        .i_color     (s_axis_tdata[31:0]),
        .i_id        (s_axis_tdata[47:32]),
        .i_out_free  (out_free),
        .o_ready     (s_axis_tready),
        .o_s1        (s1),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_we    (ram_we),
        .o_ram_wdata (ram_wdata)
    );

    onma_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line0 (
        .i_clk   (i_clk),
        .i_we    (ram_we[0]),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (line0)
    );

    onma_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line1 (
        .i_clk   (i_clk),
        .i_we    (ram_we[1]),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (line1)
    );

    onma_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1         (s1),
        .i_line0      (line0),
        .i_line1      (line1),
        .i_background (cfg.background),
        .i_out_ready  (m_axis_tready),
        .o_out_free   (out_free),
        .o_out_valid  (m_axis_tvalid),
        .o_color      (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

/* hw/rtl/onma_checker.sv */
module onma_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import onma_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $past(i_rst_n, 2))
        else $error("result beat too soon after reset");

    a_bg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && paddr[3:2] == REG_BACKGROUND &&
        $past(psel && penable && pwrite && pready && paddr[3:2] == REG_BACKGROUND)
        |-> prdata == $past(pwdata))
        else $error("background register readback mismatch");

endmodule

bind object_masked_neighbour_average_unit onma_assert u_checker (.*);

/* tb/sv/onma_checker.sv */
module onma_checker
    import onma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pixel_color[31:0], object_id[47:32]
    input  logic        s_axis_tuser,   // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // filtered_color[31:0]
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_average;

    t_average              pending_averages[$];
    t_entry                line_store [2*MAX_WIDTH];
    t_entry                window [9];
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic [COLOR_BITS-1:0] background_reg;
    int unsigned           col_pos;
    int unsigned           row_pos;
    int                    mismatch_count;
    t_average              got;
    t_average              want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [COLOR_BITS-1:0] masked_mean(int cc, bit left_ok, bit right_ok);
        logic [ID_BITS-1:0]    centre;
        int                    sum [CHANNELS];
        logic [COLOR_BITS-1:0] mean;
        int                    col;
        centre = window[3+cc].id;
        if (centre == '0) begin
            return background_reg;
        end
        sum  = '{default: 0};
        mean = '0;
        for (int rr = 0; rr < 3; rr++) begin
            for (int k = 0; k < 3; k++) begin
                col = cc + k;
                if (!(rr == 1 && k == 1) && (k != 0 || left_ok) && (k != 2 || right_ok) &&
                    col >= 1 && col <= 3) begin
                    if (window[rr*3+col-1].id == centre) begin
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            sum[ch] += window[rr*3+col-1].color[ch*CH_BITS +: CH_BITS];
                        end
                    end
                end
            end
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            mean[ch*CH_BITS +: CH_BITS] = CH_BITS'(sum[ch] >> 3);
        end
        return mean;
    endfunction

    task automatic advance_raster(input logic kind, input logic [COLOR_BITS-1:0] color,
                                  input logic [ID_BITS-1:0] id);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned slot_old;
        int unsigned slot_mid;
        t_entry      top_e;
        t_entry      mid_e;
        t_entry      bot_e;
        t_average    avg;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        r = row_pos;
        c = col_pos;
        if (c >= w || r > h + 1) begin
            c = 0;
            r = 0;
        end
        row_pos = r;
        col_pos = c;
        // flush while pixels are still due is dropped
        if (r < h && kind == KIND_FLUSH) begin
            return;
        end
        // start of a line: last pixel of the line above
        if (c == 0 && r >= 2) begin
            avg.color = masked_mean(2, w >= 2, 1'b0);
            avg.last  = (r == h + 1);
            pending_averages.push_back(avg);
        end
        if (r == h + 1) begin
            row_pos = 0;
            col_pos = 0;
            return;
        end
        slot_old = (r % 2) * MAX_WIDTH + c;
        slot_mid = ((r + 1) % 2) * MAX_WIDTH + c;
        top_e = (r >= 2) ? line_store[slot_old] : '0;
        mid_e = (r >= 1) ? line_store[slot_mid] : '0;
        bot_e = '0;
        if (r < h) begin
            bot_e.id    = id;
            bot_e.color = color;
            line_store[slot_old] = bot_e;
        end
        for (int k = 0; k < 3; k++) begin
            window[k*3]   = window[k*3+1];
            window[k*3+1] = window[k*3+2];
        end
        window[2] = top_e;
        window[5] = mid_e;
        window[8] = bot_e;
        if (c >= 1 && r >= 1) begin
            avg.color = masked_mean(1, c >= 2, 1'b1);
            avg.last  = 1'b0;
            pending_averages.push_back(avg);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg      = WIDTH_RESET;
            height_reg     = HEIGHT_RESET;
            background_reg = '0;
            col_pos        = 0;
            row_pos        = 0;
            mismatch_count = 0;
            for (int i = 0; i < 9; i++) begin
                window[i] = '0;
            end
            for (int i = 0; i < 2*MAX_WIDTH; i++) begin
                line_store[i] = '0;
            end
            pending_averages.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH: begin
                        width_reg = pwdata[DIM_BITS-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_HEIGHT: begin
                        height_reg = pwdata[DIM_BITS-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    REG_BACKGROUND: begin
                        background_reg = pwdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_raster(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.color = m_axis_tdata;
                got.last  = m_axis_tlast;
                if (pending_averages.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, got color %h last %b",
                             $time, got.color, got.last);
                    mismatch_count++;
                end else begin
                    want = pending_averages.pop_front();
                    if (want.color !== got.color) begin
                        $display("%0t: filtered_color expected %h got %h",
                                 $time, want.color, got.color);
                        mismatch_count++;
                    end
                    if (want.last !== got.last) begin
                        $display("%0t: frame_last expected %b got %b",
                                 $time, want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_averages.size();
    end

endmodule

/* tb/sv/object_masked_neighbour_average_unit_tb.sv */
module object_masked_neighbour_average_unit_tb;

    import onma_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1020;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // pixel_color[31:0], object_id[47:32]
    logic        s_axis_tuser = 1'b0; // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // filtered_color[31:0]
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    bit steady = 1'b0;
    int fed = 0;
    int cur_w = 640;
    int cur_h = 480;
    int quiet_cycles = 0;
    int rx_hold = 0;
    int rx_draw;

    object_masked_neighbour_average_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    onma_checker average_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side stall drawn per beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = steady ? 0 : $urandom_range(0, 5);
            rx_hold       <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_hold > 1) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_hold       <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int wr, input int hr);
        reg_write(REG_WIDTH, wr);
        reg_write(REG_HEIGHT, hr);
        cur_w = (wr == 0) ? 1 : ((wr > MAX_WIDTH) ? MAX_WIDTH : wr);
        cur_h = (hr == 0) ? 1 : hr;
    endtask

    task automatic push_beat(input logic kind, input logic [31:0] color, input logic [15:0] id);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {id, color};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // let results drain, then the pipeline empties
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_frame(input bit abandon);
        int          total;
        int          stop_at;
        int          sel;
        logic [15:0] pal_a;
        logic [15:0] pal_b;
        logic [15:0] id;
        logic [31:0] color;
        total   = cur_w * cur_h;
        stop_at = abandon ? $urandom_range(0, total - 1) : total;
        pal_a   = 16'($urandom_range(1, 65535));
        pal_b   = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
        for (int k = 0; k < stop_at; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                push_beat(KIND_FLUSH, $urandom, 16'($urandom));
            end
            sel   = $urandom_range(0, 9);
            id    = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'($urandom) :
                    (sel < 6) ? pal_a : pal_b;
            color = ($urandom_range(0, 4) == 0) ? 32'hFFFFFFFF : $urandom;
            push_beat(KIND_PIXEL, color, id);
            fed++;
        end
        if (!abandon) begin
            for (int k = 0; k <= cur_w; k++) begin
                push_beat(($urandom_range(0, 7) == 0) ? KIND_PIXEL : KIND_FLUSH,
                          $urandom, 16'($urandom));
                fed++;
            end
        end
    endtask

    task automatic random_phase();
        int frames;
        steady = ($urandom_range(0, 3) == 0);
        set_geometry(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8),
                     $urandom_range(1, 6));
        reg_write(REG_BACKGROUND, $urandom);
        frames = $urandom_range(1, 3);
        for (int f = 1; f < frames; f++) begin
            run_frame(1'b0);
        end
        run_frame($urandom_range(0, 4) == 0);
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full match in the centre, frame edges, early flush and late pixel
        set_geometry(3, 3);
        reg_write(REG_BACKGROUND, 32'hA5C30F96);
        for (int k = 0; k < 9; k++) begin
            push_beat(KIND_PIXEL, (k == 4) ? 32'h00000000 : 32'hFFFFFFFF, 16'd5);
            if (k == 4) begin
                push_beat(KIND_FLUSH, $urandom, 16'($urandom));
            end
        end
        for (int k = 0; k < 4; k++) begin
            push_beat((k == 1) ? KIND_PIXEL : KIND_FLUSH, $urandom, 16'($urandom));
        end
        settle();

        // zero sizes, background pixel
        set_geometry(0, 0);
        push_beat(KIND_PIXEL, 32'hFFFFFFFF, 16'h0000);
        push_beat(KIND_FLUSH, 32'h00000000, 16'h0000);
        push_beat(KIND_FLUSH, 32'hFFFFFFFF, 16'hFFFF);
        settle();

        // top id value beside background pixels
        set_geometry(2, 2);
        for (int k = 0; k < 4; k++) begin
            push_beat(KIND_PIXEL, $urandom, (k == 1) ? 16'h0000 : 16'hFFFF);
        end
        for (int k = 0; k < 3; k++) begin
            push_beat(KIND_FLUSH, $urandom, 16'($urandom));
        end
        settle();

        while (fed < RANDOM_ITEMS) begin
            random_phase();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/onma_pkg.sv
hw/rtl/onma_ram.sv
hw/rtl/onma_regs.sv
hw/rtl/onma_ctrl.sv
hw/rtl/onma_window.sv
hw/rtl/object_masked_neighbour_average_unit.sv
hw/rtl/onma_checker.sv
tb/sv/onma_checker.sv
tb/sv/object_masked_neighbour_average_unit_tb.sv
